/* rtl/npdf_pkg.sv */
// shared constants, codes and types for the nearest point disparity fill block
package npdf_pkg;

  // table geometry
  localparam int MAX_POINTS = 1024;
  localparam int FRAC_BITS  = 4;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 16;
  localparam int PIX_W   = 12;
  localparam int DISP_W  = 11;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // distance limit: dist * LIMIT_DEN < LIMIT_NUM * 2^(2*FRAC_BITS)
  // holds exactly when dist is below the rounded-up quotient
  localparam longint unsigned LIMIT_NUM = 64'd9999999999;
  localparam longint unsigned LIMIT_DEN = 64'd1000;
  localparam longint unsigned LIMIT_Q   =
    ((LIMIT_NUM << (2 * FRAC_BITS)) + LIMIT_DEN - 64'd1) / LIMIT_DEN;
  localparam logic [DIST_W-1:0] DIST_LIMIT = LIMIT_Q[DIST_W-1:0];

  typedef struct packed {
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic signed [DISP_W-1:0] disp;
  } point_t;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
    point_t           pt;
  } feed_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DISP_W-1:0] disp;
  } result_t;

endpackage

/* rtl/npdf_if.sv */
// valid/ready channel interfaces for item input and query results
interface npdf_in_if;
  import npdf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [COORD_W-1:0]       point_x;
  logic [COORD_W-1:0]       point_y;
  logic signed [DISP_W-1:0] point_disparity;
  logic [PIX_W-1:0]         pixel_row;
  logic [PIX_W-1:0]         pixel_col;

  modport source (
    output valid, operation, point_x, point_y, point_disparity, pixel_row, pixel_col,
    input  ready
  );
  modport sink (
    input  valid, operation, point_x, point_y, point_disparity, pixel_row, pixel_col,
    output ready
  );
endinterface

interface npdf_out_if;
  import npdf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] nearest_disparity;
  logic [IDX_W-1:0]         nearest_index;
  logic                     table_empty;

  modport source (
    output valid, nearest_disparity, nearest_index, table_empty,
    input  ready
  );
  modport sink (
    input  valid, nearest_disparity, nearest_index, table_empty,
    output ready
  );
endinterface

/* rtl/npdf_cell.sv */
// one point storage cell of the rotating point ring
module npdf_cell (
  input  logic            clk,
  input  logic            load_en,
  input  npdf_pkg::point_t load_pt,
  input  logic            shift_en,
  input  npdf_pkg::point_t next_pt,
  output npdf_pkg::point_t pt
);
  import npdf_pkg::*;

  point_t pt_r;

  // append writes the cell, a scan step takes the neighbor's point
  always_ff @(posedge clk) begin
    if (load_en) begin
      pt_r <= load_pt;
    end else if (shift_en) begin
      pt_r <= next_pt;
    end
  end

  assign pt = pt_r;

endmodule

/* rtl/npdf_dist.sv */
// distance pipeline and running nearest point selection
module npdf_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [npdf_pkg::COORD_W-1:0] col_s,
  input  logic [npdf_pkg::COORD_W-1:0] row_s,
  input  npdf_pkg::feed_t              feed,
  output logic                         done,
  output npdf_pkg::result_t            res
);
  import npdf_pkg::*;

  // stage 1: absolute differences
  logic                     s1_vld_r;
  logic                     s1_last_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic signed [DISP_W-1:0] s1_disp_r;
  logic [COORD_W-1:0]       s1_dx_r;
  logic [COORD_W-1:0]       s1_dy_r;

  // stage 2: squares
  logic                     s2_vld_r;
  logic                     s2_last_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic signed [DISP_W-1:0] s2_disp_r;
  logic [SQ_W-1:0]          s2_sqx_r;
  logic [SQ_W-1:0]          s2_sqy_r;

  // stage 3: best so far
  logic [DIST_W-1:0]        best_r;
  logic                     found_r;
  logic [IDX_W-1:0]         bidx_r;
  logic signed [DISP_W-1:0] bdisp_r;
  logic                     done_r;

  logic [DIST_W-1:0] dist_sum;
  logic              qual;
  logic              take;

  // control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= feed.vld;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r && s2_last_r;
    end
  end

  // difference stage
  always_ff @(posedge clk) begin
    s1_last_r <= feed.last;
    s1_idx_r  <= feed.idx;
    s1_disp_r <= feed.pt.disp;
    s1_dx_r   <= (col_s >= feed.pt.x) ? (col_s - feed.pt.x) : (feed.pt.x - col_s);
    s1_dy_r   <= (row_s >= feed.pt.y) ? (row_s - feed.pt.y) : (feed.pt.y - row_s);
  end

  // square stage
  always_ff @(posedge clk) begin
    s2_last_r <= s1_last_r;
    s2_idx_r  <= s1_idx_r;
    s2_disp_r <= s1_disp_r;
    s2_sqx_r  <= SQ_W'(s1_dx_r) * SQ_W'(s1_dx_r);
    s2_sqy_r  <= SQ_W'(s1_dy_r) * SQ_W'(s1_dy_r);
  end

  // sum, limit test and strict compare keeps the earliest on ties
  assign dist_sum = DIST_W'(s2_sqx_r) + DIST_W'(s2_sqy_r);
  assign qual     = dist_sum < DIST_LIMIT;
  assign take     = qual && (!found_r || (dist_sum < best_r));

  // point 0 always seeds the choice, so it wins when nothing qualifies
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      if (s2_idx_r == '0) begin
        best_r  <= dist_sum;
        found_r <= qual;
        bidx_r  <= s2_idx_r;
        bdisp_r <= s2_disp_r;
      end else if (take) begin
        best_r  <= dist_sum;
        found_r <= 1'b1;
        bidx_r  <= s2_idx_r;
        bdisp_r <= s2_disp_r;
      end
    end
  end

  assign done     = done_r;
  assign res.idx  = bidx_r;
  assign res.disp = bdisp_r;

endmodule

/* rtl/nearest_point_disparity_fill.sv */
// nearest point disparity fill: point ring of cells with a distance pipeline
// clear and append act when accepted; an append to a full table is dropped
// a query turns the whole ring once, with the input closed until the turn ends
// and the result is loaded into the output register; the result passes the
// difference, square and best stages; an empty-table query skips the scan
// synchronous active-low reset empties the table; point contents are not reset
module nearest_point_disparity_fill (
  input  logic       clk,
  input  logic       rst_n,
  npdf_in_if.sink    in_ch,
  npdf_out_if.source out_ch
);
  import npdf_pkg::*;

  logic [CNT_W-1:0]   count_r;
  logic               scan_r;
  logic [IDX_W-1:0]   t_r;
  logic               pend_r;
  logic               got_r;
  logic               empty_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;

  logic                     out_vld_r;
  logic signed [DISP_W-1:0] out_disp_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic                     out_empty_r;

  logic    in_acc;
  logic    app_acc;
  logic    qry_acc;
  logic    out_ld;
  logic    dist_done;
  result_t dist_res;
  feed_t   feed;
  point_t  load_pt;
  point_t  cell_pt [MAX_POINTS];

  assign in_ch.ready = !scan_r && !pend_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign app_acc     = in_acc && (in_ch.operation == OP_APPEND);
  assign qry_acc     = in_acc && (in_ch.operation == OP_QUERY);

  assign load_pt.x    = in_ch.point_x;
  assign load_pt.y    = in_ch.point_y;
  assign load_pt.disp = in_ch.point_disparity;

  // ring of point cells, cell 0 faces the distance unit
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_POINTS;
    npdf_cell u_cell (
      .clk      (clk),
      .load_en  (app_acc && (count_r == CNT_W'(i))),
      .load_pt  (load_pt),
      .shift_en (scan_r),
      .next_pt  (cell_pt[NXT]),
      .pt       (cell_pt[i])
    );
  end

  // point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && (in_ch.operation == OP_CLEAR)) begin
      count_r <= '0;
    end else if (app_acc && (count_r != CNT_W'(MAX_POINTS))) begin
      count_r <= count_r + 1'b1;
    end
  end

  // query control: rotate the ring a full turn, then wait for the result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= 1'b0;
      t_r     <= '0;
      pend_r  <= 1'b0;
      got_r   <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      if (qry_acc) begin
        pend_r <= 1'b1;
        t_r    <= '0;
        if (count_r == '0) begin
          empty_r <= 1'b1;
          got_r   <= 1'b1;
        end else begin
          empty_r <= 1'b0;
          got_r   <= 1'b0;
          scan_r  <= 1'b1;
        end
      end else begin
        if (scan_r) begin
          t_r <= t_r + 1'b1;
          if (t_r == IDX_W'(MAX_POINTS - 1)) begin
            scan_r <= 1'b0;
          end
        end
        if (out_ld) begin
          pend_r <= 1'b0;
          got_r  <= 1'b0;
        end else if (dist_done) begin
          got_r <= 1'b1;
        end
      end
    end
  end

  // pixel position scaled to the point grid
  always_ff @(posedge clk) begin
    if (qry_acc) begin
      col_r <= COORD_W'(in_ch.pixel_col) << FRAC_BITS;
      row_r <= COORD_W'(in_ch.pixel_row) << FRAC_BITS;
    end
  end

  // feed the point at the head of the ring
  assign feed.vld  = scan_r && (CNT_W'(t_r) < count_r);
  assign feed.last = (CNT_W'(t_r) == (count_r - 1'b1));
  assign feed.idx  = t_r;
  assign feed.pt   = cell_pt[0];

  npdf_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .col_s (col_r),
    .row_s (row_r),
    .feed  (feed),
    .done  (dist_done),
    .res   (dist_res)
  );

  // output register
  assign out_ld = pend_r && got_r && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_empty_r <= empty_r;
      out_disp_r  <= empty_r ? '0 : dist_res.disp;
      out_idx_r   <= empty_r ? '0 : dist_res.idx;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.nearest_disparity = out_disp_r;
  assign out_ch.nearest_index     = out_idx_r;
  assign out_ch.table_empty       = out_empty_r;

`ifndef SYNTHESIS
  // the distance unit reports once per query, only while a query waits
  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    dist_done |-> (pend_r && !got_r))
    else $error("distance result without a pending query transaction");

  // the ring ends each scan back at its home alignment
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(scan_r) |-> (t_r == '0))
    else $error("ring scan ended off alignment");

  // the point count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table size");

  // the empty-table answer never goes through the distance unit
  a_empty_noscan: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && empty_r) |-> (!scan_r && !feed.vld))
    else $error("scan running on an empty table");
`endif

endmodule
